### hdl/chol_pkg.sv
// chol_pkg: shared types, sizes and address helpers for the cholesky solver
// depends on nothing; used by the controller, the datapath and the top level
package chol_pkg;

    localparam int DIM       = 4;
    localparam int IW        = $clog2(DIM);
    localparam int TRI_N     = DIM * (DIM + 1) / 2;
    localparam int A_RHS     = TRI_N;
    localparam int L_BASE    = TRI_N + DIM;
    localparam int Y_BASE    = L_BASE + TRI_N;
    localparam int X_BASE    = Y_BASE + DIM;
    localparam int MEM_DEPTH = X_BASE + DIM;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int DW        = 32;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_BASE,
        OP_MUL,
        OP_RND,
        OP_ACC,
        OP_DIV,
        OP_SQRT,
        OP_EMIT,
        OP_CLR
    } op_t;

    typedef struct packed {
        op_t           op;
        logic          load_in;
        logic [AW-1:0] addr_a;
        logic [AW-1:0] addr_b;
        logic [AW-1:0] wr_addr;
        logic          kind;
        logic [1:0]    row;
        logic [1:0]    col;
        logic          last;
    } cmd_t;

    typedef struct packed {
        logic unit_busy;
        logic out_hold;
    } sts_t;

    // packed lower-triangle index of (r, c)
    function automatic logic [AW-1:0] tri_idx(input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
        logic [AW-1:0] rr;
        rr = AW'(r);
        return AW'((rr * (rr + 1'b1)) >> 1) + AW'(c);
    endfunction

    function automatic logic [AW-1:0] l_addr(input logic [IW-1:0] r,
                                             input logic [IW-1:0] c);
        return AW'(L_BASE) + tri_idx(r, c);
    endfunction

endpackage

### hdl/chol_if.sv
// chol_if: valid/ready channel interfaces for the load items and the results
// depends on nothing
interface chol_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, row, col, value, last, input ready);
    modport sink (input valid, row, col, value, last, output ready);
endinterface

interface chol_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [1:0]         row_res;
    logic [1:0]         col_res;
    logic signed [31:0] value_res;
    logic               fault;
    logic               last_res;

    modport source (output valid, kind, row_res, col_res, value_res, fault, last_res,
                    input ready);
    modport sink (input valid, kind, row_res, col_res, value_res, fault, last_res,
                  output ready);
endinterface

### hdl/chol_ram.sv
// chol_ram: generic ram, one write port and two registered read ports
// depends on nothing
module chol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### hdl/chol_ctrl.sv
// chol_ctrl: sequencer for load, factor, forward, back substitution and emit
// depends on chol_pkg; drives the datapath through cmd_t, reads sts_t
module chol_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    output logic            in_ready,
    output chol_pkg::cmd_t  cmd,
    input  chol_pkg::sts_t  sts
);
    import chol_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE_RD,
        S_BASE,
        S_P_RD,
        S_P_MUL,
        S_P_RND,
        S_P_ACC,
        S_DEN_RD,
        S_START,
        S_WAIT,
        S_E_RD,
        S_E_LD
    } state_t;

    typedef enum logic [2:0] {
        PH_FACT,
        PH_FWD,
        PH_BACK,
        PH_EMIT_L,
        PH_EMIT_X
    } phase_t;

    localparam logic [IW-1:0] LAST_I = IW'(DIM - 1);

    state_t        state_reg;
    phase_t        phase_reg;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] j_reg;
    logic [IW-1:0] k_reg;

    logic          fire;
    logic [IW-1:0] nprod;
    logic [IW-1:0] jb;
    logic          is_sqrt;
    logic [AW-1:0] base_addr;
    logic [AW-1:0] pa_addr;
    logic [AW-1:0] pb_addr;
    logic [AW-1:0] den_addr;
    logic [AW-1:0] dst_addr;
    logic [AW-1:0] emit_addr;

    assign in_ready = (state_reg == S_IDLE);
    assign fire     = in_valid && in_ready;
    assign jb       = i_reg + IW'(1) + k_reg;
    assign is_sqrt  = (phase_reg == PH_FACT) && (j_reg == i_reg);

    always_comb
    begin
        nprod     = j_reg;
        base_addr = tri_idx(i_reg, j_reg);
        pa_addr   = l_addr(i_reg, k_reg);
        pb_addr   = l_addr(j_reg, k_reg);
        den_addr  = l_addr(j_reg, j_reg);
        dst_addr  = l_addr(i_reg, j_reg);
        emit_addr = l_addr(i_reg, j_reg);
        case (phase_reg)
            PH_FWD:
            begin
                nprod     = i_reg;
                base_addr = AW'(A_RHS) + AW'(i_reg);
                pb_addr   = AW'(Y_BASE) + AW'(k_reg);
                den_addr  = l_addr(i_reg, i_reg);
                dst_addr  = AW'(Y_BASE) + AW'(i_reg);
            end
            PH_BACK:
            begin
                nprod     = LAST_I - i_reg;
                base_addr = AW'(Y_BASE) + AW'(i_reg);
                pa_addr   = l_addr(jb, i_reg);
                pb_addr   = AW'(X_BASE) + AW'(jb);
                den_addr  = l_addr(i_reg, i_reg);
                dst_addr  = AW'(X_BASE) + AW'(i_reg);
            end
            PH_EMIT_X:
            begin
                emit_addr = AW'(X_BASE) + AW'(i_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.op      = OP_NOP;
        cmd.load_in = fire;
        cmd.addr_b  = pb_addr;
        cmd.wr_addr = dst_addr;
        cmd.kind    = (phase_reg == PH_EMIT_X);
        cmd.row     = 2'(i_reg);
        cmd.col     = 2'(j_reg);
        cmd.last    = (phase_reg == PH_EMIT_X) && (i_reg == LAST_I);
        cmd.addr_a  = pa_addr;
        case (state_reg)
            S_IDLE:
            begin
                if (fire && in_last)
                begin
                    cmd.op = OP_CLR;
                end
            end
            S_BASE_RD: cmd.addr_a = base_addr;
            S_BASE:
            begin
                cmd.addr_a = base_addr;
                cmd.op     = OP_BASE;
            end
            S_P_MUL: cmd.op = OP_MUL;
            S_P_RND: cmd.op = OP_RND;
            S_P_ACC: cmd.op = OP_ACC;
            S_DEN_RD: cmd.addr_a = den_addr;
            S_START:
            begin
                cmd.addr_a = den_addr;
                cmd.op     = is_sqrt ? OP_SQRT : OP_DIV;
            end
            S_E_RD: cmd.addr_a = emit_addr;
            S_E_LD:
            begin
                cmd.addr_a = emit_addr;
                cmd.op     = OP_EMIT;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_FACT;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (fire && in_last)
                    begin
                        phase_reg <= PH_FACT;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= S_BASE_RD;
                    end
                end
                S_BASE_RD: state_reg <= S_BASE;
                S_BASE:
                begin
                    k_reg     <= '0;
                    state_reg <= (nprod == '0) ? S_DEN_RD : S_P_RD;
                end
                S_P_RD:  state_reg <= S_P_MUL;
                S_P_MUL: state_reg <= S_P_RND;
                S_P_RND: state_reg <= S_P_ACC;
                S_P_ACC:
                begin
                    k_reg     <= k_reg + IW'(1);
                    state_reg <= (k_reg == nprod - IW'(1)) ? S_DEN_RD : S_P_RD;
                end
                S_DEN_RD: state_reg <= S_START;
                S_START:  state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (!sts.unit_busy)
                    begin
                        state_reg <= S_BASE_RD;
                        case (phase_reg)
                            PH_FACT:
                            begin
                                if (j_reg != i_reg)
                                begin
                                    j_reg <= j_reg + IW'(1);
                                end
                                else if (i_reg != LAST_I)
                                begin
                                    i_reg <= i_reg + IW'(1);
                                    j_reg <= '0;
                                end
                                else
                                begin
                                    phase_reg <= PH_FWD;
                                    i_reg     <= '0;
                                    j_reg     <= '0;
                                end
                            end
                            PH_FWD:
                            begin
                                if (i_reg != LAST_I)
                                begin
                                    i_reg <= i_reg + IW'(1);
                                end
                                else
                                begin
                                    phase_reg <= PH_BACK;
                                end
                            end
                            default:
                            begin
                                if (i_reg != '0)
                                begin
                                    i_reg <= i_reg - IW'(1);
                                end
                                else
                                begin
                                    phase_reg <= PH_EMIT_L;
                                    j_reg     <= '0;
                                    state_reg <= S_E_RD;
                                end
                            end
                        endcase
                    end
                end
                S_E_RD:
                begin
                    if (!sts.out_hold)
                    begin
                        state_reg <= S_E_LD;
                    end
                end
                S_E_LD:
                begin
                    state_reg <= S_E_RD;
                    if (phase_reg == PH_EMIT_L)
                    begin
                        if (j_reg != i_reg)
                        begin
                            j_reg <= j_reg + IW'(1);
                        end
                        else if (i_reg != LAST_I)
                        begin
                            i_reg <= i_reg + IW'(1);
                            j_reg <= '0;
                        end
                        else
                        begin
                            phase_reg <= PH_EMIT_X;
                            i_reg     <= '0;
                            j_reg     <= '0;
                        end
                    end
                    else if (i_reg != LAST_I)
                    begin
                        i_reg <= i_reg + IW'(1);
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/chol_dp.sv
// chol_dp: operand/result ram, multiply-accumulate, iterative divide and square root,
// output register; depends on chol_pkg and chol_ram
module chol_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  chol_pkg::cmd_t     cmd,
    output chol_pkg::sts_t     sts,
    input  logic [1:0]         in_row,
    input  logic [2:0]         in_col,
    input  logic signed [31:0] in_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_kind,
    output logic [1:0]         out_row,
    output logic [1:0]         out_col,
    output logic signed [31:0] out_value,
    output logic               out_fault,
    output logic               out_last
);
    import chol_pkg::*;

    typedef enum logic [1:0] {
        U_IDLE,
        U_DIV,
        U_SQRT,
        U_WR
    } ustate_t;

    localparam int NW = 48;

    // ram
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [DW-1:0] rdata_a;
    logic [DW-1:0] rdata_b;

    // input element placement
    logic          in_ok;
    logic [AW-1:0] in_addr;

    // multiply-accumulate
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] rnd_reg;
    logic signed [31:0] diff;
    logic               diff_pos;
    logic [31:0]        diff_mag;
    logic [31:0]        den_mag;

    // divide / square root unit
    ustate_t       u_state_reg;
    logic [5:0]    cnt_reg;
    logic [AW-1:0] u_addr_reg;
    logic [DW-1:0] u_res_reg;
    logic          neg_reg;
    logic [NW-1:0] n_reg;
    logic [31:0]   d_reg;
    logic [31:0]   rem_reg;
    logic [NW-1:0] v_reg;
    logic [NW-1:0] r_reg;
    logic [NW-1:0] b_reg;
    logic          fault_reg;

    logic [32:0]   trial;
    logic          ge;
    logic [NW-1:0] n_next;
    logic [31:0]   rem_next;
    logic [DW-1:0] q_sat;
    logic [NW-1:0] rb_sum;
    logic          take;
    logic [NW-1:0] v_next;
    logic [NW-1:0] r_next;

    // output register
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [1:0]         out_row_reg;
    logic [1:0]         out_col_reg;
    logic signed [31:0] out_value_reg;
    logic               out_fault_reg;
    logic               out_last_reg;

    chol_ram #(
        .WIDTH (DW),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (cmd.addr_a),
        .rdata_a (rdata_a),
        .raddr_b (cmd.addr_b),
        .rdata_b (rdata_b)
    );

    // rhs entries go after the packed triangle; upper triangle is dropped
    always_comb
    begin
        in_ok   = 1'b0;
        in_addr = AW'(A_RHS) + AW'(in_row);
        if (in_col == 3'(DIM))
        begin
            in_ok = 1'b1;
        end
        else if (in_col <= {1'b0, in_row})
        begin
            in_ok   = 1'b1;
            in_addr = tri_idx(IW'(in_row), IW'(in_col));
        end
    end

    assign we    = (cmd.load_in && in_ok) || (u_state_reg == U_WR);
    assign waddr = cmd.load_in ? in_addr : u_addr_reg;
    assign wdata = cmd.load_in ? DW'(in_value) : u_res_reg;

    always_comb
    begin
        if (acc_reg > 64'sh0000_0000_7FFF_FFFF)
        begin
            diff = 32'sh7FFF_FFFF;
        end
        else if (acc_reg < -64'sh0000_0000_8000_0000)
        begin
            diff = -32'sh7FFF_FFFF - 32'sd1;
        end
        else
        begin
            diff = acc_reg[31:0];
        end
    end

    assign diff_pos = !diff[31] && (diff != '0);
    assign diff_mag = diff[31] ? 32'(-diff) : 32'(diff);
    assign den_mag  = rdata_a[31] ? 32'(-rdata_a) : rdata_a;

    // restoring divide, one quotient bit a cycle
    assign trial    = {rem_reg, n_reg[NW-1]};
    assign ge       = trial >= {1'b0, d_reg};
    assign rem_next = ge ? 32'(trial - {1'b0, d_reg}) : trial[31:0];
    assign n_next   = {n_reg[NW-2:0], ge};

    always_comb
    begin
        if (neg_reg)
        begin
            q_sat = (n_next > NW'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                         : 32'(~n_next[31:0] + 32'd1);
        end
        else
        begin
            q_sat = (n_next > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : n_next[31:0];
        end
    end

    // digit-by-digit square root, one result bit a cycle
    assign rb_sum = r_reg + b_reg;
    assign take   = v_reg >= rb_sum;
    assign v_next = take ? v_reg - rb_sum : v_reg;
    assign r_next = take ? (r_reg >> 1) + b_reg : (r_reg >> 1);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_BASE: acc_reg  <= 64'(signed'(rdata_a));
            OP_MUL:  prod_reg <= signed'(rdata_a) * signed'(rdata_b);
            OP_RND:  rnd_reg  <= (prod_reg + 64'sd32768) >>> 16;
            OP_ACC:  acc_reg  <= acc_reg - rnd_reg;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_state_reg <= U_IDLE;
            fault_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_CLR)
            begin
                fault_reg <= 1'b0;
            end
            case (u_state_reg)
                U_IDLE:
                begin
                    u_addr_reg <= cmd.wr_addr;
                    if (cmd.op == OP_DIV)
                    begin
                        n_reg   <= {diff_mag, 16'b0};
                        d_reg   <= den_mag;
                        rem_reg <= '0;
                        neg_reg <= diff[31] ^ rdata_a[31];
                        cnt_reg <= 6'(NW - 1);
                        if (rdata_a == '0)
                        begin
                            u_res_reg   <= '0;
                            u_state_reg <= U_WR;
                        end
                        else
                        begin
                            u_state_reg <= U_DIV;
                        end
                    end
                    else if (cmd.op == OP_SQRT)
                    begin
                        v_reg   <= {diff_mag, 16'b0};
                        r_reg   <= '0;
                        b_reg   <= NW'(1) << (NW - 2);
                        cnt_reg <= 6'(NW / 2 - 1);
                        if (!diff_pos)
                        begin
                            fault_reg   <= 1'b1;
                            u_res_reg   <= '0;
                            u_state_reg <= U_WR;
                        end
                        else
                        begin
                            u_state_reg <= U_SQRT;
                        end
                    end
                end
                U_DIV:
                begin
                    n_reg   <= n_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        u_res_reg   <= q_sat;
                        u_state_reg <= U_WR;
                    end
                end
                U_SQRT:
                begin
                    v_reg   <= v_next;
                    r_reg   <= r_next;
                    b_reg   <= b_reg >> 2;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        u_res_reg   <= r_next[DW-1:0];
                        u_state_reg <= U_WR;
                    end
                end
                default: u_state_reg <= U_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT)
        begin
            out_kind_reg  <= cmd.kind;
            out_row_reg   <= cmd.row;
            out_col_reg   <= cmd.col;
            out_value_reg <= signed'(rdata_a);
            out_fault_reg <= fault_reg;
            out_last_reg  <= cmd.last;
        end
    end

    assign sts.unit_busy = (u_state_reg != U_IDLE);
    assign sts.out_hold  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_fault = out_fault_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |-> !out_valid_reg)
        else $error("result loaded over a pending transaction");

    a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DIV || cmd.op == OP_SQRT) |-> u_state_reg == U_IDLE)
        else $error("divide/sqrt started while busy");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |-> u_state_reg != U_WR)
        else $error("load and result write on the same ram port");

    a_pivot_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SQRT && !diff_pos) |=> fault_reg)
        else $error("non-positive pivot did not raise fault");
`endif

endmodule

### hdl/cholesky_solve_4x4.sv
// Cholesky factor and solve of a 4x4 SPD system in Q15.16. Load the lower triangle and the
// right-hand side, one element per transaction (col 4 is the rhs entry of that row); the
// transaction with last set starts the run, during which no load is taken. The run time is set
// by the shared one-bit-per-cycle unit, which computes the 14 quotients (48 steps each) and the
// 4 square roots one at a time, and by the 22 products on the single multiplier.
// Then 14 results leave one at a time when the sink is ready: the 10 factor entries
// row by row, then the 4 solution entries. Upper-triangle elements are ignored.
// depends on chol_pkg, chol_if, chol_ctrl and chol_dp
module cholesky_solve_4x4 (
    input logic      clk,
    input logic      rst_n,
    chol_in_if.sink  req,
    chol_out_if.source rsp
);
    import chol_pkg::*;

    cmd_t cmd;
    sts_t sts;

    chol_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_last  (req.last),
        .in_ready (req.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    chol_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_row    (req.row),
        .in_col    (req.col),
        .in_value  (req.value),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_kind  (rsp.kind),
        .out_row   (rsp.row_res),
        .out_col   (rsp.col_res),
        .out_value (rsp.value_res),
        .out_fault (rsp.fault),
        .out_last  (rsp.last_res)
    );

endmodule

### tb/sv/tb_chol_if.sv
`timescale 1ns / 100ps
// tb_chol_types: testbench type for the queue of expected result transactions
// depends on nothing
package tb_chol_types;
    typedef struct {
        logic               kind;
        logic [1:0]         row_res;
        logic [1:0]         col_res;
        logic signed [31:0] value_res;
        logic               fault;
        logic               last_res;
    } entry_t;
endpackage

### tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for cholesky_solve_4x4, loads directed cases and random systems
// depends on tb_chol_types, chol_if and the rtl top; predicts factor and solution in q15.16
module tb;
    import tb_chol_types::*;

    logic clk = 0;
    logic rst_n = 0;
    chol_in_if req ();
    chol_out_if rsp ();

    cholesky_solve_4x4 DUT (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always #5 clk = ~clk;

    logic signed [31:0] mat_q [10];
    logic signed [31:0] rhs_q [4];
    logic signed [31:0] fac_q [10];
    logic signed [31:0] fwd_q [4];
    logic signed [31:0] sol_q [4];
    logic               fault_q;
    entry_t             pending_entries [$];
    int                 errors = 0;
    int                 send_idle = 0, recv_stall = 0;

    typedef struct {
        logic [1:0] row;
        logic [2:0] col;
        logic [31:0] value;
        logic last;
    } load_t;

    function automatic int tri_pos(int r, int c);
        return r * (r + 1) / 2 + c;
    endfunction

    function automatic longint sat_word(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint qmul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 32768;
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] qdiv(longint num, logic signed [31:0] den);
        if (den == 0) return 0;
        return 32'(sat_word((sat_word(num) * 65536) / longint'(den)));
    endfunction

    function automatic logic [31:0] root64(logic [63:0] v);
        logic [63:0] res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (v >= res + bit_v)
            begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end
            else
                res >>= 1;
            bit_v >>= 2;
        end
        return res[31:0];
    endfunction

    // store the element; on last, factor, solve and queue the 14 entries
    task automatic predict_solve(load_t it);
        longint acc, d;
        entry_t e;
        if (it.col == 4) rhs_q[it.row] = it.value;
        else if (it.col <= it.row) mat_q[tri_pos(it.row, it.col)] = it.value;
        if (!it.last) return;
        fault_q = 0;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < i; j++)
            begin
                acc = 0;
                for (int k = 0; k < j; k++)
                    acc += qmul(fac_q[tri_pos(i, k)], fac_q[tri_pos(j, k)]);
                fac_q[tri_pos(i, j)] = qdiv(longint'(mat_q[tri_pos(i, j)]) - acc,
                                            fac_q[tri_pos(j, j)]);
            end
            acc = 0;
            for (int k = 0; k < i; k++)
                acc += qmul(fac_q[tri_pos(i, k)], fac_q[tri_pos(i, k)]);
            d = sat_word(longint'(mat_q[tri_pos(i, i)]) - acc);
            if (d <= 0)
            begin
                fault_q = 1;
                fac_q[tri_pos(i, i)] = 0;
            end
            else
                fac_q[tri_pos(i, i)] = root64(64'(d) << 16);
        end
        for (int i = 0; i < 4; i++)
        begin
            acc = rhs_q[i];
            for (int j = 0; j < i; j++) acc -= qmul(fac_q[tri_pos(i, j)], fwd_q[j]);
            fwd_q[i] = qdiv(acc, fac_q[tri_pos(i, i)]);
        end
        for (int i = 3; i >= 0; i--)
        begin
            acc = fwd_q[i];
            for (int j = 3; j > i; j--) acc -= qmul(fac_q[tri_pos(j, i)], sol_q[j]);
            sol_q[i] = qdiv(acc, fac_q[tri_pos(i, i)]);
        end
        for (int i = 0; i < 4; i++)
            for (int j = 0; j <= i; j++)
            begin
                e = '{1'b0, 2'(i), 2'(j), fac_q[tri_pos(i, j)], fault_q, 1'b0};
                pending_entries.push_back(e);
            end
        for (int i = 0; i < 4; i++)
        begin
            e = '{1'b1, 2'(i), 2'd0, sol_q[i], fault_q, i == 3};
            pending_entries.push_back(e);
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // valid stays high after the accepting edge until the next call or wait_drained
    task automatic send_load(load_t it);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            req.valid <= 0;
            @(negedge clk);
        end
        req.valid <= 1;
        req.row <= it.row;
        req.col <= it.col;
        req.value <= it.value;
        req.last <= it.last;
        do @(posedge clk); while (!req.ready);
        predict_solve(it);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 0;
        while (pending_entries.size() != 0) @(negedge clk);
    endtask

    // one problem: full lower triangle and rhs in random order, last on the final one
    task automatic send_system(int mode);
        load_t items [$];
        load_t it;
        logic [31:0] diag_v;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < r; c++)
            begin
                it.row = r; it.col = c;
                it.value = (mode == 0) ? 32'($signed($urandom_range(0, 65536)) - 32768)
                                       : $urandom;
                it.last = 0;
                items.push_back(it);
            end
            diag_v = (mode == 0) ? 32'($urandom_range(131072, 1048576)) : $urandom;
            it.row = r; it.col = r; it.value = diag_v; it.last = 0;
            items.push_back(it);
            it.col = 4;
            it.value = (mode == 2) ? $urandom : 32'($signed($urandom_range(0, 524288)) - 262144);
            items.push_back(it);
            if ($urandom_range(3) == 0)
            begin
                // ignored noise: upper triangle or out-of-range column
                it.col = $urandom_range(0, 1) ? 3'($urandom_range(5, 7)) : 3'(r + 1);
                if (it.col == 4) it.col = 5;
                it.value = $urandom;
                items.push_back(it);
            end
        end
        items.shuffle();
        // the final transaction must be a real element so every entry is written
        while (items[items.size() - 1].col > 4 ||
               (items[items.size() - 1].col != 4 &&
                items[items.size() - 1].col > items[items.size() - 1].row))
        begin
            items.shuffle();
        end
        items[items.size() - 1].last = 1;
        foreach (items[i]) send_load(items[i]);
    endtask

    always @(posedge clk)
    begin
        entry_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_entries.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                e = pending_entries.pop_front();
                if (rsp.kind !== e.kind) report_mismatch("kind", rsp.kind, e.kind);
                if (rsp.row_res !== e.row_res) report_mismatch("row", rsp.row_res, e.row_res);
                if (rsp.col_res !== e.col_res) report_mismatch("col", rsp.col_res, e.col_res);
                if (rsp.value_res !== e.value_res)
                    report_mismatch("value", rsp.value_res, e.value_res);
                if (rsp.fault !== e.fault) report_mismatch("fault", rsp.fault, e.fault);
                if (rsp.last_res !== e.last_res)
                    report_mismatch("last", rsp.last_res, e.last_res);
            end
        end
    end

    always @(negedge clk)
        rsp.ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);

    initial
    begin
        load_t dir_tbl [$];
        req.valid = 0; req.row = 0; req.col = 0; req.value = 0; req.last = 0;
        rsp.ready = 1;
        foreach (mat_q[i]) mat_q[i] = 0;
        foreach (fac_q[i]) fac_q[i] = 0;
        foreach (rhs_q[i]) begin rhs_q[i] = 0; fwd_q[i] = 0; sol_q[i] = 0; end
        fault_q = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // directed: identity times four with rhs ones, then pivot faults and extremes
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < r; c++) dir_tbl.push_back('{2'(r), 3'(c), 32'h0, 1'b0});
            dir_tbl.push_back('{2'(r), 3'(r), 32'h0004_0000, 1'b0});
            dir_tbl.push_back('{2'(r), 3'd4, 32'h0001_0000, r == 3});
        end
        dir_tbl.push_back('{2'd1, 3'd3, 32'hFFFF_FFFF, 1'b0});   // upper triangle, ignored
        dir_tbl.push_back('{2'd2, 3'd7, 32'h8000_0000, 1'b0});   // column out of range
        dir_tbl.push_back('{2'd0, 3'd0, 32'h8000_0000, 1'b0});   // negative pivot
        dir_tbl.push_back('{2'd3, 3'd3, 32'h7FFF_FFFF, 1'b0});
        dir_tbl.push_back('{2'd3, 3'd0, 32'h7FFF_FFFF, 1'b0});
        dir_tbl.push_back('{2'd3, 3'd4, 32'h8000_0000, 1'b1});
        dir_tbl.push_back('{2'd0, 3'd0, 32'h0000_0000, 1'b1});   // zero pivot
        dir_tbl.push_back('{2'd0, 3'd0, 32'h7FFF_FFFF, 1'b1});
        foreach (dir_tbl[i]) send_load(dir_tbl[i]);
        wait_drained();
        // random systems under each idling phase
        for (int p = 0; p < 4; p++)
        begin
            send_idle = (p == 1 || p == 3) ? (p == 1 ? 45 : 35) : 0;
            recv_stall = (p >= 2) ? (p == 2 ? 45 : 35) : 0;
            for (int s = 0; s < 6; s++)
                send_system(s % 5 == 4 ? 2 : (s % 7 == 6 ? 1 : 0));
            wait_drained();
        end
        send_idle = 0; recv_stall = 0;
        repeat (2000) @(negedge clk);
        if (pending_entries.size() != 0) errors++;
        if (errors == 0)
            $display("[cholesky_solve_4x4] OK");
        else
            $display("[cholesky_solve_4x4] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[cholesky_solve_4x4] ERROR");
        $finish;
    end
endmodule

### sim.f
hdl/chol_pkg.sv
hdl/chol_if.sv
hdl/chol_ram.sv
hdl/chol_ctrl.sv
hdl/chol_dp.sv
hdl/cholesky_solve_4x4.sv
tb/sv/tb_chol_if.sv
tb/sv/tb.sv
